/* design/scfla_pkg.sv */
// Shared types and constants for the size-class allocator.
// Used by the front, queue, back and top modules; depends on nothing.
package scfla_pkg;

    // default pool geometry
    localparam int NUM_CHUNKS_DEF = 16;
    localparam int NUM_BOXES_DEF  = 4;
    localparam int CHUNK_LOG_DEF  = 15;

    // fixed field widths
    localparam int ADDR_W    = 19;
    localparam int BYTES_W   = 32;
    localparam int REQ_W     = 8;
    localparam int BOX_W     = 6;
    localparam int CLASS_W   = 5;
    localparam int SIZE_W    = 4;
    localparam int COUNT_W   = 17;
    localparam int MIN_CLASS = 3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // queue between front and back
    localparam int Q_DEPTH = 2;

    typedef enum logic [2:0] {
        ST_ALLOCATED = 3'd0,
        ST_FREED     = 3'd1,
        ST_OVERSIZE  = 3'd2,
        ST_ZERO_SIZE = 3'd3,
        ST_NO_MEMORY = 3'd4,
        ST_EXT_FREE  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        K_ALLOC,
        K_FREE,
        K_DIRECT
    } kind_t;

    // one classified request
    typedef struct packed {
        kind_t               kind;
        status_t             status;
        logic [BOX_W-1:0]    box;
        logic [CLASS_W-1:0]  cls;
        logic [ADDR_W-1:0]   addr;
    } req_t;

endpackage

/* design/size_class_free_list_allocator_top.sv */
// Top level of the size-class free-list allocator: front, queue and back.
// Depends on scfla_pkg, scfla_front, scfla_queue and scfla_back.

// Serves allocate and free items over a pool of NUM_CHUNKS chunks of 2^CHUNK_LOG
// bytes, with per-box LIFO lists for each power-of-two class. Items are classified
// on entry and queued; the list sequencer handles one at a time. Oversize, zero and
// external-free items go straight to the result; a free reads the chunk tags, then
// the registered head and count (a free into an unclaimed chunk stops after the
// tags); an allocate reads the head and count, then the link of the head. An
// allocate that claims a fresh chunk first links every block split from it, and
// each box tried after the home box repeats the head and count read. A result held
// by a stalled output keeps the sequencer from finishing the next item.
module size_class_free_list_allocator_top #(
    parameter int NUM_CHUNKS = scfla_pkg::NUM_CHUNKS_DEF,
    parameter int NUM_BOXES  = scfla_pkg::NUM_BOXES_DEF,
    parameter int CHUNK_LOG  = scfla_pkg::CHUNK_LOG_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // requester[7:0], byte_count[39:8], block_address[58:40]
    input  logic [1:0]  s_axis_tuser,  // operation[0], external_block[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // granted_address[18:0], size_class[22:19]
    output logic [2:0]  m_axis_tuser   // status[2:0]
);

    scfla_pkg::req_t    front_req;
    scfla_pkg::req_t    q_data;
    logic               q_full;
    logic               q_not_empty;
    logic               q_pop;
    logic               push;
    scfla_pkg::status_t out_status;
    logic [scfla_pkg::ADDR_W-1:0] out_address;
    logic [scfla_pkg::SIZE_W-1:0] out_size_class;

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;
    assign m_axis_tdata  = {1'b0, out_size_class, out_address};
    assign m_axis_tuser  = out_status;

    scfla_front #(
        .NUM_BOXES (NUM_BOXES),
        .CHUNK_LOG (CHUNK_LOG)
    ) u_front (
        .operation      (s_axis_tuser[0]),
        .external_block (s_axis_tuser[1]),
        .requester      (s_axis_tdata[7:0]),
        .byte_count     (s_axis_tdata[39:8]),
        .block_address  (s_axis_tdata[58:40]),
        .req            (front_req)
    );

    scfla_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_req),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    scfla_back #(
        .NUM_CHUNKS (NUM_CHUNKS),
        .NUM_BOXES  (NUM_BOXES),
        .CHUNK_LOG  (CHUNK_LOG)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_status     (out_status),
        .out_address    (out_address),
        .out_size_class (out_size_class)
    );

endmodule

/* design/scfla_front.sv */
// Front end: takes request items and classifies them into queue entries.
// Depends on scfla_pkg.
module scfla_front #(
    parameter int NUM_BOXES = scfla_pkg::NUM_BOXES_DEF,
    parameter int CHUNK_LOG = scfla_pkg::CHUNK_LOG_DEF
) (
    input  logic                           operation,
    input  logic                           external_block,
    input  logic [scfla_pkg::REQ_W-1:0]    requester,
    input  logic [scfla_pkg::BYTES_W-1:0]  byte_count,
    input  logic [scfla_pkg::ADDR_W-1:0]   block_address,
    output scfla_pkg::req_t                req
);

    localparam logic [scfla_pkg::BYTES_W-1:0] BYTES_LIMIT =
        scfla_pkg::BYTES_W'((64'(1) << CHUNK_LOG) - 64'd2);
    localparam int SEARCH_W   = CHUNK_LOG + 1;
    localparam int HOME_TAB_N = 1 << scfla_pkg::REQ_W;

    typedef logic [HOME_TAB_N-1:0][scfla_pkg::BOX_W-1:0] home_tab_t;

    // home box for every requester value, built at elaboration
    function automatic home_tab_t build_home_tab();
        home_tab_t t;
        t = '0;
        for (int i = 0; i < HOME_TAB_N; i++)
        begin
            t[i] = scfla_pkg::BOX_W'(i % NUM_BOXES);
        end
        return t;
    endfunction

    localparam home_tab_t HOME_TAB = build_home_tab();

    logic                   oversize;
    logic [SEARCH_W-1:0]    plus_one;
    logic [scfla_pkg::CLASS_W-1:0] cls;
    logic [scfla_pkg::BOX_W-1:0]   home;

    assign oversize = byte_count > BYTES_LIMIT;
    assign plus_one = SEARCH_W'(byte_count) + SEARCH_W'(1);
    assign home     = HOME_TAB[requester];

    // class = position of the top one of bytes+1, plus one, at least MIN_CLASS
    always_comb
    begin
        cls = scfla_pkg::CLASS_W'(scfla_pkg::MIN_CLASS);
        for (int i = 0; i < SEARCH_W; i++)
        begin
            if (plus_one[i] && (i + 1 > scfla_pkg::MIN_CLASS))
            begin
                cls = scfla_pkg::CLASS_W'(i + 1);
            end
        end
    end

    // build the queue entry
    always_comb
    begin
        req.box    = home;
        req.cls    = cls;
        req.addr   = block_address;
        req.kind   = scfla_pkg::K_DIRECT;
        req.status = scfla_pkg::ST_FREED;
        if (!operation)
        begin
            priority if (oversize)
            begin
                req.status = scfla_pkg::ST_OVERSIZE;
            end
            else if (byte_count == '0)
            begin
                req.status = scfla_pkg::ST_ZERO_SIZE;
            end
            else
            begin
                req.kind   = scfla_pkg::K_ALLOC;
                req.status = scfla_pkg::ST_ALLOCATED;
            end
        end
        else if (external_block)
        begin
            req.status = scfla_pkg::ST_EXT_FREE;
        end
        else
        begin
            req.kind = scfla_pkg::K_FREE;
        end
    end

endmodule

/* design/scfla_queue.sv */
// Short request queue between front and back.
// Depends on scfla_pkg.
module scfla_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scfla_pkg::req_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output scfla_pkg::req_t pop_data
);

    localparam int PTR_W = $clog2(scfla_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(scfla_pkg::Q_DEPTH + 1);

    scfla_pkg::req_t    entries [scfla_pkg::Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full      = count_reg == CNT_W'(scfla_pkg::Q_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = entries[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(scfla_pkg::Q_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(scfla_pkg::Q_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* design/scfla_back.sv */
// Back end: free-list sequencer with list memories, chunk tags and result register.
// Depends on scfla_pkg.
module scfla_back #(
    parameter int NUM_CHUNKS = scfla_pkg::NUM_CHUNKS_DEF,
    parameter int NUM_BOXES  = scfla_pkg::NUM_BOXES_DEF,
    parameter int CHUNK_LOG  = scfla_pkg::CHUNK_LOG_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_not_empty,
    input  scfla_pkg::req_t               q_data,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output scfla_pkg::status_t            out_status,
    output logic [scfla_pkg::ADDR_W-1:0]  out_address,
    output logic [scfla_pkg::SIZE_W-1:0]  out_size_class
);

    localparam int MINC        = scfla_pkg::MIN_CLASS;
    localparam int NUM_CLASSES = CHUNK_LOG - MINC + 1;
    localparam int NUM_LISTS   = NUM_BOXES * NUM_CLASSES;
    localparam int LI_W        = $clog2(NUM_LISTS);
    localparam int SLOT_W      = $clog2(NUM_CHUNKS) + CHUNK_LOG - MINC;
    localparam int TOTAL_SLOTS = NUM_CHUNKS << (CHUNK_LOG - MINC);
    localparam int CIDX_W      = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int FRESH_W     = $clog2(NUM_CHUNKS + 1);
    localparam int CNT_W       = scfla_pkg::COUNT_W;
    localparam int AW          = scfla_pkg::ADDR_W;
    localparam int CW          = scfla_pkg::CLASS_W;
    localparam int BW          = scfla_pkg::BOX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE_TAG,
        S_LOOK,
        S_CHECK,
        S_FILL,
        S_POP_LINK,
        S_POP_DONE,
        S_RESULT
    } state_t;

    // memories
    logic [SLOT_W-1:0]  links_mem  [TOTAL_SLOTS];
    logic [SLOT_W-1:0]  heads_mem  [NUM_LISTS];
    logic [CNT_W-1:0]   counts_mem [NUM_LISTS];
    logic [NUM_LISTS-1:0] count_valid_reg;
    logic [BW-1:0]      owner_tags [NUM_CHUNKS];
    logic [CW-1:0]      class_tags [NUM_CHUNKS];

    logic [SLOT_W-1:0]  link_q;
    logic [SLOT_W-1:0]  head_q;
    logic [CNT_W-1:0]   cnt_q;
    logic               cnt_valid_q;

    // sequencer registers
    state_t             state_reg, state_next;
    logic               is_free_reg, is_free_next;
    logic [BW-1:0]      box_reg, box_next;
    logic [BW-1:0]      tries_reg, tries_next;
    logic [CW-1:0]      cls_reg, cls_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [LI_W-1:0]    li_reg, li_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SLOT_W-1:0]  head_reg, head_next;
    logic [SLOT_W-1:0]  prev_reg, prev_next;
    logic [SLOT_W-1:0]  stride_reg, stride_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [FRESH_W-1:0] fresh_reg, fresh_next;
    scfla_pkg::status_t res_status_reg, res_status_next;
    logic [AW-1:0]      res_addr_reg, res_addr_next;
    logic [CW-1:0]      res_cls_reg, res_cls_next;
    logic               out_valid_reg, out_valid_next;
    scfla_pkg::status_t out_status_reg, out_status_next;
    logic [AW-1:0]      out_addr_reg, out_addr_next;
    logic [CW-1:0]      out_cls_reg, out_cls_next;

    // write strobes
    logic               link_we;
    logic [SLOT_W-1:0]  link_wa, link_wd;
    logic               list_we;
    logic [SLOT_W-1:0]  head_wd;
    logic [CNT_W-1:0]   cnt_wd;
    logic               tag_we;

    logic [AW-1:0]      chunk_of_addr;
    logic [CIDX_W-1:0]  chunk_idx;
    logic [CW-1:0]      tag_cls;
    logic [CNT_W-1:0]   cnt_now;
    logic [CNT_W-1:0]   fill_n;
    logic [AW-1:0]      cls_mask;

    function automatic logic [LI_W-1:0] list_index(input logic [BW-1:0] b,
                                                   input logic [CW-1:0] c);
        return LI_W'(int'(b) * NUM_CLASSES + int'(c) - MINC);
    endfunction

    assign chunk_of_addr  = addr_reg >> CHUNK_LOG;
    assign chunk_idx      = CIDX_W'(chunk_of_addr);
    assign tag_cls        = class_tags[chunk_idx];
    assign cnt_now        = cnt_valid_q ? cnt_q : '0;
    assign fill_n         = CNT_W'(1) << (CHUNK_LOG - int'(cls_reg));
    assign cls_mask       = (AW'(1) << tag_cls) - AW'(1);
    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_address    = out_addr_reg;
    assign out_size_class = out_cls_reg[scfla_pkg::SIZE_W-1:0];

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        is_free_next    = is_free_reg;
        box_next        = box_reg;
        tries_next      = tries_reg;
        cls_next        = cls_reg;
        addr_next       = addr_reg;
        li_next         = li_reg;
        slot_next       = slot_reg;
        head_next       = head_reg;
        prev_next       = prev_reg;
        stride_next     = stride_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        fresh_next      = fresh_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_cls_next    = res_cls_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_cls_next    = out_cls_reg;
        q_pop           = 1'b0;
        link_we         = 1'b0;
        link_wa         = slot_reg;
        link_wd         = head_q;
        list_we         = 1'b0;
        head_wd         = slot_reg;
        cnt_wd          = cnt_now + 1'b1;
        tag_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop         = 1'b1;
                    box_next      = q_data.box;
                    cls_next      = q_data.cls;
                    addr_next     = q_data.addr;
                    tries_next    = '0;
                    res_addr_next = '0;
                    res_cls_next  = '0;
                    is_free_next  = q_data.kind == scfla_pkg::K_FREE;
                    unique case (q_data.kind)
                        scfla_pkg::K_ALLOC:
                        begin
                            li_next    = list_index(q_data.box, q_data.cls);
                            state_next = S_LOOK;
                        end
                        scfla_pkg::K_FREE:
                        begin
                            state_next = S_FREE_TAG;
                        end
                        default:
                        begin
                            res_status_next = q_data.status;
                            state_next      = S_RESULT;
                        end
                    endcase
                end
            end

            // look up the chunk's owner and class
            S_FREE_TAG:
            begin
                res_status_next = scfla_pkg::ST_FREED;
                if (chunk_of_addr < AW'(fresh_reg))
                begin
                    cls_next   = tag_cls;
                    li_next    = list_index(owner_tags[chunk_idx], tag_cls);
                    slot_next  = SLOT_W'((addr_reg & ~cls_mask) >> MINC);
                    state_next = S_LOOK;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end

            // head and count are read here
            S_LOOK:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (is_free_reg)
                begin
                    if (cnt_now < scfla_pkg::COUNT_MAX)
                    begin
                        link_we      = 1'b1;
                        list_we      = 1'b1;
                        res_cls_next = cls_reg;
                    end
                    state_next = S_RESULT;
                end
                else if (cnt_now != '0)
                begin
                    head_next  = head_q;
                    cnt_next   = cnt_now;
                    state_next = S_POP_LINK;
                end
                else if (fresh_reg < FRESH_W'(NUM_CHUNKS))
                begin
                    // claim a fresh chunk and split it
                    tag_we      = 1'b1;
                    fresh_next  = fresh_reg + 1'b1;
                    slot_next   = SLOT_W'(fresh_reg) << (CHUNK_LOG - MINC);
                    stride_next = SLOT_W'(1) << (int'(cls_reg) - MINC);
                    prev_next   = head_q;
                    idx_next    = '0;
                    cnt_next    = fill_n;
                    state_next  = S_FILL;
                end
                else if (tries_reg == BW'(NUM_BOXES - 1))
                begin
                    res_status_next = scfla_pkg::ST_NO_MEMORY;
                    state_next      = S_RESULT;
                end
                else
                begin
                    box_next   = (box_reg == BW'(NUM_BOXES - 1)) ? '0 : box_reg + 1'b1;
                    li_next    = list_index((box_reg == BW'(NUM_BOXES - 1)) ? '0
                                                                           : box_reg + 1'b1,
                                            cls_reg);
                    tries_next = tries_reg + 1'b1;
                    state_next = S_LOOK;
                end
            end

            // one block linked per cycle, ascending address
            S_FILL:
            begin
                link_we   = 1'b1;
                link_wa   = slot_reg;
                link_wd   = prev_reg;
                prev_next = slot_reg;
                slot_next = slot_reg + stride_reg;
                if (idx_reg == cnt_reg - 1'b1)
                begin
                    head_next  = slot_reg;
                    state_next = S_POP_LINK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // link of the head is read here
            S_POP_LINK:
            begin
                state_next = S_POP_DONE;
            end

            S_POP_DONE:
            begin
                list_we         = 1'b1;
                head_wd         = link_q;
                cnt_wd          = cnt_reg - 1'b1;
                res_status_next = scfla_pkg::ST_ALLOCATED;
                res_addr_next   = AW'({head_reg, {MINC{1'b0}}});
                res_cls_next    = cls_reg;
                state_next      = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_cls_next    = res_cls_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fresh_reg       <= '0;
            out_valid_reg   <= 1'b0;
            count_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
            if (list_we)
            begin
                count_valid_reg[li_reg] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        is_free_reg    <= is_free_next;
        box_reg        <= box_next;
        tries_reg      <= tries_next;
        cls_reg        <= cls_next;
        addr_reg       <= addr_next;
        li_reg         <= li_next;
        slot_reg       <= slot_next;
        head_reg       <= head_next;
        prev_reg       <= prev_next;
        stride_reg     <= stride_next;
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_cls_reg    <= res_cls_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_cls_reg    <= out_cls_next;
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            links_mem[link_wa] <= link_wd;
        end
        link_q <= links_mem[head_reg];
    end

    // list head and count memories
    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            heads_mem[li_reg]  <= head_wd;
            counts_mem[li_reg] <= cnt_wd;
        end
        head_q      <= heads_mem[li_reg];
        cnt_q       <= counts_mem[li_reg];
        cnt_valid_q <= count_valid_reg[li_reg];
    end

    // chunk tags
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            owner_tags[CIDX_W'(fresh_reg)] <= box_reg;
            class_tags[CIDX_W'(fresh_reg)] <= cls_reg;
        end
    end

endmodule
